/* design/ray_sphere_intersect_macros.svh */
// Assertion macros for the ray/sphere intersect block.
// Used by ray_sphere_intersect.sv; no other dependencies.
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH
`ifndef SYNTHESIS
`define RSI_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rsi check failed");
`define RSI_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rsi check failed");
`else
`define RSI_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define RSI_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif
`endif

/* design/rsi_pkg.sv */
// Shared constants and types for the ray/sphere intersect block.
// No dependencies.
`default_nettype none
package rsi_pkg;

  localparam int COORD_W   = 32;
  localparam int RADIUS_W  = 31;
  localparam int COLOR_W   = 16;
  localparam int NORMAL_W  = 16;
  localparam int CFG_IDX_W = 3;

  // square root: 64-bit radicand, one root bit per stage
  localparam int SQRT_IN_W  = 64;
  localparam int SQRT_OUT_W = 32;
  localparam int SQRT_LAT   = SQRT_OUT_W;

  // divider: one quotient bit per stage
  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_LAT   = DIV_NUM_W;

  // total register stages from input to the output register
  localparam int PIPE_DEPTH = 5 + SQRT_LAT + 1 + DIV_LAT + 5 + SQRT_LAT + 1 + DIV_LAT;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_CENTER_Z    = 3'd2,
    CFG_RADIUS      = 3'd3,
    CFG_COLOR_RED   = 3'd4,
    CFG_COLOR_GREEN = 3'd5,
    CFG_COLOR_BLUE  = 3'd6
  } cfg_idx_t;

endpackage
`default_nettype wire

/* design/rsi_ifs.sv */
// Request channel interfaces: ray requests in, hit results out.
// Depends on rsi_pkg.
`default_nettype none
interface rsi_ray_if;
  logic                              valid;
  logic                              ready;
  logic signed [rsi_pkg::COORD_W-1:0] origin_x;
  logic signed [rsi_pkg::COORD_W-1:0] origin_y;
  logic signed [rsi_pkg::COORD_W-1:0] origin_z;
  logic signed [rsi_pkg::COORD_W-1:0] dir_x;
  logic signed [rsi_pkg::COORD_W-1:0] dir_y;
  logic signed [rsi_pkg::COORD_W-1:0] dir_z;
  logic signed [rsi_pkg::COORD_W-1:0] t_min;
  logic signed [rsi_pkg::COORD_W-1:0] t_max;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  t_min, t_max, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                t_min, t_max, output ready);
endinterface

interface rsi_hit_if;
  logic                               valid;
  logic                               ready;
  logic                               is_hit;
  logic signed [rsi_pkg::COORD_W-1:0]  hit_distance;
  logic signed [rsi_pkg::NORMAL_W-1:0] normal_x;
  logic signed [rsi_pkg::NORMAL_W-1:0] normal_y;
  logic signed [rsi_pkg::NORMAL_W-1:0] normal_z;
  logic [rsi_pkg::COLOR_W-1:0]         hit_red;
  logic [rsi_pkg::COLOR_W-1:0]         hit_green;
  logic [rsi_pkg::COLOR_W-1:0]         hit_blue;
  modport source (output valid, is_hit, hit_distance, normal_x, normal_y, normal_z,
                  hit_red, hit_green, hit_blue, input ready);
  modport sink (input valid, is_hit, hit_distance, normal_x, normal_y, normal_z,
                hit_red, hit_green, hit_blue, output ready);
endinterface
`default_nettype wire

/* design/ray_sphere_intersect.sv */
// Ray/sphere intersect: one ray request (origin, direction, t window, Q16.16)
// is tested against the sphere held in the cfg registers, and one result
// request comes back per ray with hit flag, distance, Q1.15 unit normal and
// sphere color (all zero on a miss). A new ray is taken every cycle while the
// output is not stalled. The pipeline holds two bit-serial square roots (32 stages
// each) and two rows of bit-serial dividers (50 stages each), one bit per stage.
// The whole pipeline moves as one while the output register is empty or
// being taken, so a stalled result holds everything behind it. Config must
// be written only while no ray is in flight; the block does not enforce this.
// Depends on rsi_pkg, rsi_ifs, rsi_sqrt, rsi_div and ray_sphere_intersect_macros.svh.
`default_nettype none
`include "ray_sphere_intersect_macros.svh"
module ray_sphere_intersect (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [rsi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rsi_pkg::COORD_W-1:0]       cfg_wdata,
  rsi_ray_if.sink                                in_ch,
  rsi_hit_if.source                              out_ch
);
  localparam int SQ = rsi_pkg::SQRT_LAT;
  localparam int DV = rsi_pkg::DIV_LAT;
  localparam int N  = rsi_pkg::PIPE_DEPTH;
  localparam int CW = rsi_pkg::COORD_W;

  typedef logic [2:0][CW-1:0] vec3_t;
  typedef logic [2:0][63:0]   vec3w_t;

  // side data riding along the first square root
  typedef struct packed {
    logic                         ok;
    logic [CW-1:0]                h;
    logic [rsi_pkg::RADIUS_W-1:0] a;
    vec3_t                        w;
    vec3_t                        d;
    logic [CW-1:0]                tmin;
    logic [CW-1:0]                tmax;
  } sq1_t;

  // side data riding along the distance dividers
  typedef struct packed {
    logic          ok;
    logic          neg_n;
    logic          neg_f;
    vec3_t         w;
    vec3_t         d;
    logic [CW-1:0] tmin;
    logic [CW-1:0] tmax;
  } dv1_t;

  // side data riding along the length square root
  typedef struct packed {
    logic          ok;
    logic [CW-1:0] t;
    vec3_t         p;
  } sq2_t;

  // side data riding along the normal dividers
  typedef struct packed {
    logic          ok;
    logic [CW-1:0] t;
    logic [2:0]    neg;
    logic          lzero;
  } dv2_t;

  // ---------------- config registers ----------------
  vec3_t                          center_r;
  logic [rsi_pkg::RADIUS_W-1:0]   radius_r;
  logic [2:0][rsi_pkg::COLOR_W-1:0] color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
      radius_r <= rsi_pkg::RADIUS_W'(65536);
      color_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rsi_pkg::CFG_CENTER_X:    center_r[0] <= cfg_wdata;
        rsi_pkg::CFG_CENTER_Y:    center_r[1] <= cfg_wdata;
        rsi_pkg::CFG_CENTER_Z:    center_r[2] <= cfg_wdata;
        rsi_pkg::CFG_RADIUS:      radius_r    <= cfg_wdata[rsi_pkg::RADIUS_W-1:0];
        rsi_pkg::CFG_COLOR_RED:   color_r[0]  <= cfg_wdata[rsi_pkg::COLOR_W-1:0];
        rsi_pkg::CFG_COLOR_GREEN: color_r[1]  <= cfg_wdata[rsi_pkg::COLOR_W-1:0];
        rsi_pkg::CFG_COLOR_BLUE:  color_r[2]  <= cfg_wdata[rsi_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  // Single advance strobe: everything shifts when the output slot is empty or being taken.
  logic         adv;
  logic         out_valid_r;
  logic [N-1:0] vld_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[N-2:0], in_ch.valid};
      out_valid_r <= vld_r[N-1];
    end
  end

  // ---------------- S1: w = origin - center ----------------
  vec3_t              org, dir;
  logic signed [CW:0] w_full [3];
  logic               ok1;

  assign org = {in_ch.origin_z, in_ch.origin_y, in_ch.origin_x};
  assign dir = {in_ch.dir_z, in_ch.dir_y, in_ch.dir_x};

  always_comb begin
    ok1 = 1'b1;
    for (int i = 0; i < 3; i++) begin
      w_full[i] = $signed({org[i][CW-1], org[i]}) - $signed({center_r[i][CW-1], center_r[i]});
      if (w_full[i][CW] != w_full[i][CW-1]) ok1 = 1'b0;
    end
  end

  logic          ok1_r;
  vec3_t         w1_r, d1_r;
  logic [CW-1:0] tmin1_r, tmax1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok1_r <= ok1;
      for (int i = 0; i < 3; i++) w1_r[i] <= w_full[i][CW-1:0];
      d1_r    <= dir;
      tmin1_r <= in_ch.t_min;
      tmax1_r <= in_ch.t_max;
    end
  end

  // ---------------- S2: products ----------------
  logic          ok2_r;
  vec3w_t        dd2_r, dw2_r, ww2_r;
  logic [61:0]   rr2_r;
  vec3_t         w2_r, d2_r;
  logic [CW-1:0] tmin2_r, tmax2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok2_r <= ok1_r;
      for (int i = 0; i < 3; i++) begin
        dd2_r[i] <= $signed(d1_r[i]) * $signed(d1_r[i]);
        dw2_r[i] <= $signed(d1_r[i]) * $signed(w1_r[i]);
        ww2_r[i] <= $signed(w1_r[i]) * $signed(w1_r[i]);
      end
      rr2_r   <= radius_r * radius_r;
      w2_r    <= w1_r;
      d2_r    <= d1_r;
      tmin2_r <= tmin1_r;
      tmax2_r <= tmax1_r;
    end
  end

  // ---------------- S3: a, h, c with range checks ----------------
  logic [63:0]        asum;
  logic signed [49:0] hsum, csum;
  logic               ok3;

  always_comb begin
    asum = dd2_r[0] + dd2_r[1] + dd2_r[2];
    hsum = 50'($signed(dw2_r[0]) >>> 16) + 50'($signed(dw2_r[1]) >>> 16)
         + 50'($signed(dw2_r[2]) >>> 16);
    csum = 50'($signed(ww2_r[0]) >>> 16) + 50'($signed(ww2_r[1]) >>> 16)
         + 50'($signed(ww2_r[2]) >>> 16) - $signed({4'b0000, rr2_r[61:16]});
    ok3 = ok2_r
        && (asum[63:47] == '0) && (asum[46:16] != '0)
        && ((hsum[49:31] == '0) || (hsum[49:31] == '1))
        && ((csum[49:31] == '0) || (csum[49:31] == '1));
  end

  logic                         ok3_r;
  logic [rsi_pkg::RADIUS_W-1:0] a3_r;
  logic [CW-1:0]                h3_r, c3_r;
  vec3_t                        w3_r, d3_r;
  logic [CW-1:0]                tmin3_r, tmax3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok3_r   <= ok3;
      a3_r    <= asum[46:16];
      h3_r    <= hsum[CW-1:0];
      c3_r    <= csum[CW-1:0];
      w3_r    <= w2_r;
      d3_r    <= d2_r;
      tmin3_r <= tmin2_r;
      tmax3_r <= tmax2_r;
    end
  end

  // ---------------- S4: h*h and a*c ----------------
  logic                         ok4_r;
  logic signed [63:0]           hh4_r, ac4_r;
  logic [CW-1:0]                h4_r;
  logic [rsi_pkg::RADIUS_W-1:0] a4_r;
  vec3_t                        w4_r, d4_r;
  logic [CW-1:0]                tmin4_r, tmax4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok4_r   <= ok3_r;
      hh4_r   <= $signed(h3_r) * $signed(h3_r);
      ac4_r   <= $signed({1'b0, a3_r}) * $signed(c3_r);
      h4_r    <= h3_r;
      a4_r    <= a3_r;
      w4_r    <= w3_r;
      d4_r    <= d3_r;
      tmin4_r <= tmin3_r;
      tmax4_r <= tmax3_r;
    end
  end

  // ---------------- S5: discriminant ----------------
  logic signed [64:0] disc;

  assign disc = $signed({hh4_r[63], hh4_r}) - $signed({ac4_r[63], ac4_r});

  logic [63:0] rad5_r;
  sq1_t        side5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rad5_r       <= disc[63:0];
      side5_r.ok   <= ok4_r && (disc > 65'sd0);
      side5_r.h    <= h4_r;
      side5_r.a    <= a4_r;
      side5_r.w    <= w4_r;
      side5_r.d    <= d4_r;
      side5_r.tmin <= tmin4_r;
      side5_r.tmax <= tmax4_r;
    end
  end

  // ---------------- sqrt of discriminant ----------------
  logic [rsi_pkg::SQRT_OUT_W-1:0] root1;
  sq1_t                           sq1_r [SQ];

  rsi_sqrt u_sqrt_disc (
    .clk      (clk),
    .en       (adv),
    .radicand (rad5_r),
    .root     (root1)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sq1_r[0] <= side5_r;
      for (int k = 1; k < SQ; k++) sq1_r[k] <= sq1_r[k-1];
    end
  end

  // ---------------- S6: root numerators -h -/+ s ----------------
  sq1_t               sq1_out;
  logic signed [33:0] negh, num_n, num_f;
  logic [32:0]        mag_n, mag_f;

  always_comb begin
    sq1_out = sq1_r[SQ-1];
    negh    = -$signed({{2{sq1_out.h[CW-1]}}, sq1_out.h});
    num_n   = negh - $signed({2'b00, root1});
    num_f   = negh + $signed({2'b00, root1});
    mag_n   = num_n[33] ? 33'(-num_n) : num_n[32:0];
    mag_f   = num_f[33] ? 33'(-num_f) : num_f[32:0];
  end

  logic [rsi_pkg::DIV_NUM_W-1:0] magn6_r, magf6_r;
  logic [rsi_pkg::RADIUS_W-1:0]  a6_r;
  dv1_t                          side6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      magn6_r       <= {1'b0, mag_n, 16'h0000};
      magf6_r       <= {1'b0, mag_f, 16'h0000};
      a6_r          <= sq1_out.a;
      side6_r.ok    <= sq1_out.ok;
      side6_r.neg_n <= num_n[33];
      side6_r.neg_f <= num_f[33];
      side6_r.w     <= sq1_out.w;
      side6_r.d     <= sq1_out.d;
      side6_r.tmin  <= sq1_out.tmin;
      side6_r.tmax  <= sq1_out.tmax;
    end
  end

  // ---------------- near/far distance dividers ----------------
  logic [rsi_pkg::DIV_NUM_W-1:0] q_near, q_far;
  dv1_t                          dv1_r [DV];

  rsi_div u_div_near (
    .clk (clk),
    .en  (adv),
    .num (magn6_r),
    .den ({1'b0, a6_r}),
    .quo (q_near)
  );

  rsi_div u_div_far (
    .clk (clk),
    .en  (adv),
    .num (magf6_r),
    .den ({1'b0, a6_r}),
    .quo (q_far)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dv1_r[0] <= side6_r;
      for (int k = 1; k < DV; k++) dv1_r[k] <= dv1_r[k-1];
    end
  end

  // ---------------- S7: pick root, window test ----------------
  dv1_t               dv1_out;
  logic signed [50:0] t_near, t_far, t_sel, win_lo, win_hi;
  logic               ok7;

  always_comb begin
    dv1_out = dv1_r[DV-1];
    t_near  = dv1_out.neg_n ? -$signed({1'b0, q_near}) : $signed({1'b0, q_near});
    t_far   = dv1_out.neg_f ? -$signed({1'b0, q_far}) : $signed({1'b0, q_far});
    win_lo  = 51'($signed(dv1_out.tmin));
    win_hi  = 51'($signed(dv1_out.tmax));
    // near root below the window falls back to the far root
    t_sel   = (t_near < win_lo) ? t_far : t_near;
    ok7     = dv1_out.ok && (t_sel >= win_lo) && (t_sel <= win_hi);
  end

  logic          ok7_r;
  logic [CW-1:0] t7_r;
  vec3_t         w7_r, d7_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok7_r <= ok7;
      t7_r  <= t_sel[CW-1:0];
      w7_r  <= dv1_out.w;
      d7_r  <= dv1_out.d;
    end
  end

  // ---------------- S8: t*d ----------------
  logic          ok8_r;
  vec3w_t        td8_r;
  logic [CW-1:0] t8_r;
  vec3_t         w8_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok8_r <= ok7_r;
      for (int i = 0; i < 3; i++) td8_r[i] <= $signed(t7_r) * $signed(d7_r[i]);
      t8_r  <= t7_r;
      w8_r  <= w7_r;
    end
  end

  // ---------------- S9: hit point relative to center ----------------
  logic signed [48:0] p_full [3];
  logic               ok9;

  always_comb begin
    ok9 = ok8_r;
    for (int i = 0; i < 3; i++) begin
      p_full[i] = 49'($signed(w8_r[i])) + 49'($signed(td8_r[i]) >>> 16);
      if (!((p_full[i][48:31] == '0) || (p_full[i][48:31] == '1))) ok9 = 1'b0;
    end
  end

  logic          ok9_r;
  vec3_t         p9_r;
  logic [CW-1:0] t9_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok9_r <= ok9;
      for (int i = 0; i < 3; i++) p9_r[i] <= p_full[i][CW-1:0];
      t9_r  <= t8_r;
    end
  end

  // ---------------- S10: p squares ----------------
  logic          ok10_r;
  vec3w_t        pp10_r;
  vec3_t         p10_r;
  logic [CW-1:0] t10_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok10_r <= ok9_r;
      for (int i = 0; i < 3; i++) pp10_r[i] <= $signed(p9_r[i]) * $signed(p9_r[i]);
      p10_r  <= p9_r;
      t10_r  <= t9_r;
    end
  end

  // ---------------- S11: squared length ----------------
  logic [63:0] rad11_r;
  sq2_t        side11_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rad11_r     <= pp10_r[0] + pp10_r[1] + pp10_r[2];
      side11_r.ok <= ok10_r;
      side11_r.t  <= t10_r;
      side11_r.p  <= p10_r;
    end
  end

  // ---------------- sqrt of squared length ----------------
  logic [rsi_pkg::SQRT_OUT_W-1:0] root2;
  sq2_t                           sq2_r [SQ];

  rsi_sqrt u_sqrt_len (
    .clk      (clk),
    .en       (adv),
    .radicand (rad11_r),
    .root     (root2)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sq2_r[0] <= side11_r;
      for (int k = 1; k < SQ; k++) sq2_r[k] <= sq2_r[k-1];
    end
  end

  // ---------------- S12: normal numerators |p| * 2^15 ----------------
  sq2_t          sq2_out;
  vec3_t         p_abs;

  always_comb begin
    sq2_out = sq2_r[SQ-1];
    for (int i = 0; i < 3; i++) begin
      p_abs[i] = sq2_out.p[i][CW-1] ? CW'(-$signed(sq2_out.p[i])) : sq2_out.p[i];
    end
  end

  logic [2:0][rsi_pkg::DIV_NUM_W-1:0] num12_r;
  logic [rsi_pkg::DIV_DEN_W-1:0]      len12_r;
  dv2_t                               side12_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        num12_r[i]      <= {3'b000, p_abs[i], 15'h0000};
        side12_r.neg[i] <= sq2_out.p[i][CW-1];
      end
      len12_r        <= root2;
      side12_r.ok    <= sq2_out.ok;
      side12_r.t     <= sq2_out.t;
      side12_r.lzero <= (root2 == '0);
    end
  end

  // ---------------- normal dividers ----------------
  logic [2:0][rsi_pkg::DIV_NUM_W-1:0] q_norm;
  dv2_t                               dv2_r [DV];

  for (genvar i = 0; i < 3; i++) begin : g_norm_div
    rsi_div u_div_norm (
      .clk (clk),
      .en  (adv),
      .num (num12_r[i]),
      .den (len12_r),
      .quo (q_norm[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv2_r[0] <= side12_r;
      for (int k = 1; k < DV; k++) dv2_r[k] <= dv2_r[k-1];
    end
  end

  // ---------------- output register ----------------
  dv2_t                                dv2_out;
  logic [2:0][rsi_pkg::NORMAL_W-1:0]   n_sat;

  always_comb begin
    dv2_out = dv2_r[DV-1];
    for (int i = 0; i < 3; i++) begin
      // signed quotient, clipped to the Q1.15 range
      if (dv2_out.neg[i]) begin
        if (q_norm[i] > rsi_pkg::DIV_NUM_W'(32768)) begin
          n_sat[i] = 16'h8000;
        end else begin
          n_sat[i] = 16'(rsi_pkg::DIV_NUM_W'(0) - q_norm[i]);
        end
      end else if (q_norm[i] > rsi_pkg::DIV_NUM_W'(32767)) begin
        n_sat[i] = 16'h7FFF;
      end else begin
        n_sat[i] = q_norm[i][rsi_pkg::NORMAL_W-1:0];
      end
    end
  end

  logic                              hit_r;
  logic [CW-1:0]                     dist_r;
  logic [2:0][rsi_pkg::NORMAL_W-1:0] norm_r;
  logic [2:0][rsi_pkg::COLOR_W-1:0]  rgb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r  <= dv2_out.ok;
      dist_r <= dv2_out.ok ? dv2_out.t : '0;
      // center hit: still a hit, but no direction to report
      norm_r <= (dv2_out.ok && !dv2_out.lzero) ? n_sat : '0;
      rgb_r  <= dv2_out.ok ? color_r : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.is_hit       = hit_r;
  assign out_ch.hit_distance = dist_r;
  assign out_ch.normal_x     = norm_r[0];
  assign out_ch.normal_y     = norm_r[1];
  assign out_ch.normal_z     = norm_r[2];
  assign out_ch.hit_red      = rgb_r[0];
  assign out_ch.hit_green    = rgb_r[1];
  assign out_ch.hit_blue     = rgb_r[2];

  // ---------------- checks ----------------
  `RSI_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid_r && !hit_r, (dist_r == '0) && (norm_r == '0) && (rgb_r == '0))
  `RSI_ASSERT_NXT(a_last_hold, clk, rst_n, vld_r[N-1] && !adv, vld_r[N-1])
  `RSI_ASSERT_NXT(a_out_fill, clk, rst_n, adv && vld_r[N-1], out_valid_r)

endmodule
`default_nettype wire

/* design/rsi_sqrt.sv */
// Pipelined integer square root, one root bit per register stage.
// Depends on rsi_pkg.
`default_nettype none
module rsi_sqrt (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [rsi_pkg::SQRT_IN_W-1:0]    radicand,
  output logic      [rsi_pkg::SQRT_OUT_W-1:0]   root
);
  localparam int XW  = rsi_pkg::SQRT_IN_W;
  localparam int QW  = rsi_pkg::SQRT_OUT_W;
  localparam int RW  = QW + 2;
  localparam int CW  = QW + 4;
  localparam int LAT = rsi_pkg::SQRT_LAT;

  logic [XW-1:0] x_r    [LAT];
  logic [RW-1:0] rem_r  [LAT];
  logic [QW-1:0] root_r [LAT];

  for (genvar g = 0; g < LAT; g++) begin : g_stage
    logic [XW-1:0] x_src;
    logic [RW-1:0] rem_src;
    logic [QW-1:0] root_src;
    logic [CW-1:0] cur;
    logic [CW-1:0] trial;
    logic [CW-1:0] diff;
    logic [RW-1:0] rem_nxt;
    logic [QW-1:0] root_nxt;

    if (g == 0) begin : g_first
      assign x_src    = radicand;
      assign rem_src  = '0;
      assign root_src = '0;
    end else begin : g_next
      assign x_src    = x_r[g-1];
      assign rem_src  = rem_r[g-1];
      assign root_src = root_r[g-1];
    end

    always_comb begin
      cur   = {rem_src, x_src[XW-1 -: 2]};
      trial = {2'b00, root_src, 2'b01};
      diff  = cur - trial;
      if (cur >= trial) begin
        rem_nxt  = diff[RW-1:0];
        root_nxt = {root_src[QW-2:0], 1'b1};
      end else begin
        rem_nxt  = cur[RW-1:0];
        root_nxt = {root_src[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[g]    <= {x_src[XW-3:0], 2'b00};
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
      end
    end
  end

  assign root = root_r[LAT-1];
endmodule
`default_nettype wire

/* design/rsi_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// Depends on rsi_pkg.
`default_nettype none
module rsi_div (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [rsi_pkg::DIV_NUM_W-1:0]   num,
  input  wire logic [rsi_pkg::DIV_DEN_W-1:0]   den,
  output logic      [rsi_pkg::DIV_NUM_W-1:0]   quo
);
  localparam int NW  = rsi_pkg::DIV_NUM_W;
  localparam int DW  = rsi_pkg::DIV_DEN_W;
  localparam int LAT = rsi_pkg::DIV_LAT;

  // nq holds the unshifted dividend bits on top, quotient bits below
  logic [NW-1:0] nq_r  [LAT];
  logic [DW-1:0] rem_r [LAT];
  logic [DW-1:0] den_r [LAT];

  for (genvar g = 0; g < LAT; g++) begin : g_stage
    logic [NW-1:0] nq_src;
    logic [DW-1:0] rem_src;
    logic [DW-1:0] den_src;
    logic [DW:0]   cur;
    logic [DW:0]   diff;
    logic          qbit;
    logic [DW-1:0] rem_nxt;

    if (g == 0) begin : g_first
      assign nq_src  = num;
      assign rem_src = '0;
      assign den_src = den;
    end else begin : g_next
      assign nq_src  = nq_r[g-1];
      assign rem_src = rem_r[g-1];
      assign den_src = den_r[g-1];
    end

    always_comb begin
      cur  = {rem_src, nq_src[NW-1]};
      diff = cur - {1'b0, den_src};
      qbit = (cur >= {1'b0, den_src});
      if (qbit) begin
        rem_nxt = diff[DW-1:0];
      end else begin
        rem_nxt = cur[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[g]  <= {nq_src[NW-2:0], qbit};
        rem_r[g] <= rem_nxt;
        den_r[g] <= den_src;
      end
    end
  end

  assign quo = nq_r[LAT-1];
endmodule
`default_nettype wire
